### rtl/core/eii_pkg.sv
// ============================================================================
// eii_pkg: shared types and constants for the irregular-interval EWMA
// Fixed widths of the tick fields, the Q1.31 series constants and the table
// of reciprocals that turns the series division by n into a multiplication.
// ============================================================================
package eii_pkg;

  localparam int unsigned TICK_W = 32;  // elapsed_ticks and time constant
  localparam int unsigned Y_W    = 31;  // e/(16t) as a Q0.31 fraction
  localparam int unsigned Q_W    = 32;  // Q1.31 values, up to and including 1.0
  localparam int unsigned SUM_W  = 35;  // signed partial sums of the series

  localparam logic [Q_W-1:0] Q31_ONE      = 32'h8000_0000;
  localparam logic [3:0]     SERIES_TERMS = 4'd12;

  // Status of the iterative divider as seen by the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // One row of the series divisor table. A power of two is a plain shift of
  // the scaled term; any other n multiplies by mult and shifts by shift.
  typedef struct packed {
    logic        pow2;
    logic [5:0]  shift;
    logic [31:0] mult;
  } series_tab_t;

  function automatic series_tab_t series_tab(input logic [3:0] n);
    series_tab_t row;
    row = '{pow2: 1'b1, shift: 6'd0, mult: 32'd0};
    unique case (n)
      4'd1:    row = '{pow2: 1'b1, shift: 6'd0,  mult: 32'd0};
      4'd2:    row = '{pow2: 1'b1, shift: 6'd1,  mult: 32'd0};
      4'd3:    row = '{pow2: 1'b0, shift: 6'd33, mult: 32'hAAAA_AAAB};
      4'd4:    row = '{pow2: 1'b1, shift: 6'd2,  mult: 32'd0};
      4'd5:    row = '{pow2: 1'b0, shift: 6'd34, mult: 32'hCCCC_CCCD};
      4'd6:    row = '{pow2: 1'b0, shift: 6'd34, mult: 32'hAAAA_AAAB};
      4'd7:    row = '{pow2: 1'b0, shift: 6'd34, mult: 32'h9249_2493};
      4'd8:    row = '{pow2: 1'b1, shift: 6'd3,  mult: 32'd0};
      4'd9:    row = '{pow2: 1'b0, shift: 6'd35, mult: 32'hE38E_38E4};
      4'd10:   row = '{pow2: 1'b0, shift: 6'd35, mult: 32'hCCCC_CCCD};
      4'd11:   row = '{pow2: 1'b0, shift: 6'd35, mult: 32'hBA2E_8BA3};
      4'd12:   row = '{pow2: 1'b0, shift: 6'd35, mult: 32'hAAAA_AAAB};
      default: row = '{pow2: 1'b1, shift: 6'd0,  mult: 32'd0};
    endcase
    return row;
  endfunction

endpackage

### rtl/core/eii_divider.sv
// ============================================================================
// eii_divider: restoring divider for the scaled interval
// Computes floor(elapsed * 2^27 / tau), one quotient bit per cycle, for the
// case elapsed < 16 * tau, where the quotient fits in 31 bits.
// ============================================================================
module eii_divider (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [eii_pkg::TICK_W-1:0] elapsed_i,
  input  logic [eii_pkg::TICK_W-1:0] tau_i,
  output eii_pkg::div_stat_t         stat_o,
  output logic [eii_pkg::Y_W-1:0]    quot_o
);
  import eii_pkg::*;

  logic [TICK_W-1:0] rem_q, rem_d;
  logic [TICK_W-1:0] tau_q;
  logic [Y_W-1:0]    dsh_q, quot_q;
  logic [4:0]        cnt_q;
  logic              busy_q, done_q;
  logic [TICK_W:0]   trial;
  logic              ge;

  // The remainder always stays below tau, so one extra bit covers the shift.
  assign trial = {rem_q, dsh_q[Y_W-1]};
  assign ge    = trial >= {1'b0, tau_q};
  assign rem_d = ge ? TICK_W'(trial - {1'b0, tau_q}) : trial[TICK_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 5'(Y_W - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 5'd1;
        if (cnt_q == 5'd0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= TICK_W'(elapsed_i >> 4);
      dsh_q  <= {elapsed_i[3:0], 27'd0};
      quot_q <= '0;
      tau_q  <= tau_i;
    end else if (busy_q) begin
      rem_q  <= rem_d;
      dsh_q  <= {dsh_q[Y_W-2:0], 1'b0};
      quot_q <= {quot_q[Y_W-2:0], ge};
    end
  end

  assign stat_o = '{busy: busy_q, done: done_q};
  assign quot_o = quot_q;

endmodule

### rtl/core/ewma_irregular_interval.sv
// ============================================================================
// ewma_irregular_interval: exponential moving average over irregular samples
// Blends each signed fixed-point sample into a running average with the
// weight 1 - exp(-elapsed/tau), using one shared 32x32 multiplier and an
// iterative divider under a one-hot sequencer.
// ============================================================================
//
//   channel   direction  handshake              payload
//   -------   ---------  ---------------------  ------------------------------
//   in        input      in_valid_i/in_stall_o  sample_i, elapsed_ticks_i
//   out       output     out_valid_o/out_stall_i average_o, primed_o
//   cfg       input      cfg_valid_i/cfg_ready_o cfg_data_i (time constant)
//
// One item is in work at a time. The first sample after reset goes from the
// idle state straight to the finish state, which loads it into the output
// register. A sample whose interval is at least sixteen time constants skips
// the divider and the series and passes through the weight, blend and finish
// states, with one multiplier pass per 32-bit chunk of the blend. Any other
// sample runs the bit-serial divider, the twelve series terms on the
// multiplier (two passes for each term whose divisor is not a power of two),
// the clamp, four squarings and the same blend. Reset is asynchronous and
// active low; it clears the average, the primed flag and sets the time
// constant to 1000000 ticks. A stalled result waits in the output register;
// the input stays stalled until the sequencer has handed its result over.
//
module ewma_irregular_interval #(
  parameter int unsigned SAMPLE_WIDTH     = 32,
  parameter int unsigned WEIGHT_FRAC_BITS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Configuration write channel: the time constant in ticks.
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [eii_pkg::TICK_W-1:0]        cfg_data_i,
  // Input channel.
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic signed [SAMPLE_WIDTH-1:0]    sample_i,
  input  logic [eii_pkg::TICK_W-1:0]        elapsed_ticks_i,
  // Output channel.
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [SAMPLE_WIDTH-1:0]    average_o,
  output logic                              primed_o
);
  import eii_pkg::*;

  localparam int unsigned SW     = SAMPLE_WIDTH;
  localparam int unsigned F      = WEIGHT_FRAC_BITS;
  localparam int unsigned AL_W   = F + 1;
  localparam int unsigned NCH    = (SW + 31) / 32;
  localparam int unsigned CH_W   = (NCH > 1) ? $clog2(NCH) : 1;
  localparam int unsigned PAD_W  = NCH * 32;
  localparam int unsigned ACC_W  = PAD_W + 32;
  localparam int unsigned NUM_W  = SW + F + 2;

  localparam logic [AL_W-1:0]   ALPHA_ONE = AL_W'(1) << F;
  localparam logic [TICK_W-1:0] TAU_RESET = 32'd1000000;

  // One-hot sequencer codes.
  typedef enum logic [9:0] {
    ST_IDLE      = 10'b00_0000_0001,
    ST_DIV       = 10'b00_0000_0010,
    ST_SER_MUL   = 10'b00_0000_0100,
    ST_SER_DIV   = 10'b00_0000_1000,
    ST_CLAMP     = 10'b00_0001_0000,
    ST_SQUARE    = 10'b00_0010_0000,
    ST_WEIGHT    = 10'b00_0100_0000,
    ST_BLEND_MUL = 10'b00_1000_0000,
    ST_BLEND_SUM = 10'b01_0000_0000,
    ST_FINISH    = 10'b10_0000_0000
  } state_e;

  state_e state_q, state_d;

  // Control state.
  logic [TICK_W-1:0]     tau_q;
  logic                  has_first_q;
  logic signed [SW-1:0]  avg_q;
  logic                  out_valid_q;

  // Working registers of the current item.
  logic signed [SW-1:0]  sample_q;
  logic                  large_q;
  logic [Q_W-1:0]        term_q;
  logic [Y_W-1:0]        x_q;
  logic signed [SUM_W-1:0] sum_q;
  logic [3:0]            n_q;
  logic [Q_W-1:0]        p_q;
  logic [1:0]            sq_cnt_q;
  logic [AL_W-1:0]       alpha_q;
  logic [SW-1:0]         mag_q;
  logic                  neg_q;
  logic [CH_W-1:0]       k_q;
  logic [ACC_W-1:0]      acc_q;

  // Output register.
  logic signed [SW-1:0]  average_q;
  logic                  primed_q;

  logic in_accept, is_large, div_start, fin_load;
  div_stat_t div_stat;
  logic [Y_W-1:0] quot;

  assign in_accept = in_valid_i && (state_q == ST_IDLE);
  assign in_stall_o  = (state_q != ST_IDLE);
  assign cfg_ready_o = (state_q == ST_IDLE);

  // Sixteen time constants or more, compared exactly; a zero time constant
  // always lands here, so the sample replaces the average.
  assign is_large  = {4'd0, elapsed_ticks_i} >= {tau_q, 4'd0};
  assign div_start = in_accept && has_first_q && !is_large;

  eii_divider u_divider (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .elapsed_i (elapsed_ticks_i),
    .tau_i     (tau_q),
    .stat_o    (div_stat),
    .quot_o    (quot)
  );

  // --------------------------------------------------------------------------
  // Shared multiplier. Each state that multiplies chooses its operands here,
  // and every product lands in a register before it is multiplied again.
  // --------------------------------------------------------------------------
  series_tab_t tab;
  logic [PAD_W-1:0] mag_pad;
  logic [31:0]      mul_a, mul_b;
  logic [63:0]      mul_p;

  assign tab     = series_tab(n_q);
  assign mag_pad = PAD_W'(mag_q);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      ST_SER_MUL: begin
        mul_a = term_q;
        mul_b = 32'(quot);
      end
      ST_SER_DIV: begin
        mul_a = 32'(x_q);
        mul_b = tab.mult;
      end
      ST_SQUARE: begin
        mul_a = p_q;
        mul_b = p_q;
      end
      ST_BLEND_MUL: begin
        mul_a = 32'(alpha_q);
        mul_b = mag_pad[k_q*32 +: 32];
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = 64'(mul_a) * 64'(mul_b);

  // --------------------------------------------------------------------------
  // Datapath values derived from the product and the working registers.
  // --------------------------------------------------------------------------
  logic [Y_W-1:0]          x_new;
  logic [Q_W-1:0]          term_new;
  logic signed [SUM_W-1:0] sum_new;
  logic [Q_W-1:0]          p_clamp, p_sq;
  logic [Q_W:0]            r_full, r_sh;
  logic [AL_W-1:0]         alpha_new;
  logic signed [SW:0]      diff;
  logic [SW:0]             diff_abs;
  logic [NUM_W-1:0]        prod_mag;
  logic signed [NUM_W-1:0] prod_s, avg_sh, num;

  // The scaled term term*y/2^31 stays below 2^31.
  assign x_new = mul_p[61:31];

  always_comb begin
    if (state_q == ST_SER_MUL) begin
      term_new = Q_W'({1'b0, x_new} >> tab.shift);
    end else begin
      term_new = Q_W'(mul_p >> tab.shift);
    end
  end

  // Odd terms are subtracted, even terms added.
  assign sum_new = n_q[0] ? sum_q - $signed({3'd0, term_new})
                          : sum_q + $signed({3'd0, term_new});

  always_comb begin
    if (sum_q < 0) begin
      p_clamp = '0;
    end else if (sum_q > $signed({3'd0, Q31_ONE})) begin
      p_clamp = Q31_ONE;
    end else begin
      p_clamp = sum_q[Q_W-1:0];
    end
  end

  assign p_sq = Q_W'((mul_p + (64'd1 << 30)) >> 31);

  // Round exp(-e/t) to F fraction bits, then alpha is its complement.
  assign r_full = {1'b0, p_q} + ((Q_W+1)'(1) << (30 - F));
  assign r_sh   = r_full >> (31 - F);

  always_comb begin
    if (large_q) begin
      alpha_new = ALPHA_ONE;
    end else if (r_sh > (Q_W+1)'(ALPHA_ONE)) begin
      alpha_new = '0;
    end else begin
      alpha_new = ALPHA_ONE - AL_W'(r_sh);
    end
  end

  // The blend is rewritten as avg*2^F + alpha*(sample - avg); the magnitude
  // of the difference is multiplied chunk by chunk, most significant first.
  assign diff     = $signed({sample_q[SW-1], sample_q}) - $signed({avg_q[SW-1], avg_q});
  assign diff_abs = diff[SW] ? (SW+1)'(-diff) : diff;

  assign prod_mag = acc_q[NUM_W-1:0];
  assign prod_s   = neg_q ? -$signed(prod_mag) : $signed(prod_mag);
  assign avg_sh   = $signed({{(NUM_W-SW){avg_q[SW-1]}}, avg_q}) <<< F;
  assign num      = avg_sh + prod_s + $signed(NUM_W'(1) << (F - 1));

  // --------------------------------------------------------------------------
  // Sequencer.
  // --------------------------------------------------------------------------
  assign fin_load = (state_q == ST_FINISH) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          if (!has_first_q) begin
            state_d = ST_FINISH;
          end else if (is_large) begin
            state_d = ST_WEIGHT;
          end else begin
            state_d = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (div_stat.done) begin
          state_d = ST_SER_MUL;
        end
      end
      ST_SER_MUL: begin
        if (!tab.pow2) begin
          state_d = ST_SER_DIV;
        end else if (n_q == SERIES_TERMS) begin
          state_d = ST_CLAMP;
        end
      end
      ST_SER_DIV: begin
        state_d = (n_q == SERIES_TERMS) ? ST_CLAMP : ST_SER_MUL;
      end
      ST_CLAMP: begin
        state_d = ST_SQUARE;
      end
      ST_SQUARE: begin
        if (sq_cnt_q == 2'd3) begin
          state_d = ST_WEIGHT;
        end
      end
      ST_WEIGHT: begin
        state_d = ST_BLEND_MUL;
      end
      ST_BLEND_MUL: begin
        if (k_q == '0) begin
          state_d = ST_BLEND_SUM;
        end
      end
      ST_BLEND_SUM: begin
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (fin_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      tau_q       <= TAU_RESET;
      has_first_q <= 1'b0;
      avg_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        tau_q <= cfg_data_i;
      end
      // The first sample loads the average as it stands.
      if (in_accept && !has_first_q) begin
        avg_q       <= sample_i;
        has_first_q <= 1'b1;
      end else if (state_q == ST_BLEND_SUM) begin
        avg_q <= num[F +: SW];
      end
      if (fin_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      sample_q  <= sample_i;
      large_q   <= is_large;
      term_q    <= Q31_ONE;
      sum_q     <= $signed({3'd0, Q31_ONE});
      n_q       <= 4'd1;
    end
    unique case (state_q)
      ST_SER_MUL: begin
        if (tab.pow2) begin
          term_q <= term_new;
          sum_q  <= sum_new;
          n_q    <= n_q + 4'd1;
        end else begin
          x_q <= x_new;
        end
      end
      ST_SER_DIV: begin
        term_q <= term_new;
        sum_q  <= sum_new;
        n_q    <= n_q + 4'd1;
      end
      ST_CLAMP: begin
        p_q      <= p_clamp;
        sq_cnt_q <= 2'd0;
      end
      ST_SQUARE: begin
        p_q      <= p_sq;
        sq_cnt_q <= sq_cnt_q + 2'd1;
      end
      ST_WEIGHT: begin
        alpha_q <= alpha_new;
        neg_q   <= diff[SW];
        mag_q   <= diff_abs[SW-1:0];
        k_q     <= CH_W'(NCH - 1);
        acc_q   <= '0;
      end
      ST_BLEND_MUL: begin
        acc_q <= (acc_q << 32) + ACC_W'(mul_p);
        k_q   <= k_q - CH_W'(1);
      end
      default: begin
      end
    endcase
    if (fin_load) begin
      average_q <= avg_q;
      primed_q  <= has_first_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign average_o   = average_q;
  assign primed_o    = primed_q;

  // --------------------------------------------------------------------------
  // Assertions.
  // --------------------------------------------------------------------------
`ifndef SYNTHESIS
  // An accepted beat keeps the input stalled for at least the next cycle.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input not stalled after an accepted beat");

  // Every result beat carries the primed flag.
  a_primed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> primed_o)
    else $error("result beat without the primed flag");

  // The divider only finishes while the sequencer is waiting for it.
  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.done |-> (state_q == ST_DIV))
    else $error("divider finished outside the divide state");

  // The blend weight never exceeds one.
  a_alpha_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_BLEND_MUL) |-> (alpha_q <= ALPHA_ONE))
    else $error("blend weight above one");
`endif

endmodule

### tb/ewma_irregular_interval_test.sv
`timescale 1ns / 1ps
// ============================================================================
// ewma_irregular_interval_test: self-checking bench for the irregular EWMA
// Drives sample beats and time constant writes into the block, predicts each
// running average in fixed point alongside it, and compares every result beat
// with the oldest prediction while both channels idle and stall at random.
// ============================================================================
module ewma_irregular_interval_test;

  localparam int unsigned SAMPLE_W = 32;
  localparam int unsigned WF       = 16;  // fraction bits of the blend weight
  localparam int unsigned TW       = eii_pkg::TICK_W;

  localparam longint WEIGHT_ONE  = longint'(1) << WF;
  localparam longint WEIGHT_HALF = longint'(1) << (WF - 1);
  localparam logic [TW-1:0] RESET_TAU = 32'd1000000;
  localparam logic [TW-1:0] MAX_TICKS = 32'hFFFF_FFFF;
  localparam logic signed [SAMPLE_W-1:0] MOST_NEGATIVE = 32'sh8000_0000;
  localparam logic signed [SAMPLE_W-1:0] MOST_POSITIVE = 32'sh7FFF_FFFF;

  // One result beat as the block should present it.
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] average;
    logic                       primed;
  } ewma_result_t;

  logic                       clk_i           = 1'b0;
  logic                       rst_ni          = 1'b0;
  logic                       cfg_valid_i     = 1'b0;
  logic                       cfg_ready_o;
  logic [TW-1:0]              cfg_data_i      = '0;
  logic                       in_valid_i      = 1'b0;
  logic                       in_stall_o;
  logic signed [SAMPLE_W-1:0] sample_i        = '0;
  logic [TW-1:0]              elapsed_ticks_i = '0;
  logic                       out_valid_o;
  logic                       out_stall_i     = 1'b0;
  logic signed [SAMPLE_W-1:0] average_o;
  logic                       primed_o;

  // Our own copy of the block's state and its one register.
  logic signed [SAMPLE_W-1:0] model_average = '0;
  logic                       model_primed  = 1'b0;
  logic [TW-1:0]              model_tau     = RESET_TAU;

  ewma_result_t pending_averages[$];
  int unsigned  fault_count   = 0;
  int unsigned  in_gap_pct    = 0;
  int unsigned  out_stall_pct = 0;

  ewma_irregular_interval uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .sample_i        (sample_i),
    .elapsed_ticks_i (elapsed_ticks_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .average_o       (average_o),
    .primed_o        (primed_o)
  );

  always #5 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  // Blend weight alpha = 1 - exp(-e/t) with WF fraction bits. The exponent is
  // taken as exp(-e/(16t)) from a twelve-term series in Q1.31 and then squared
  // four times; intervals of sixteen time constants or more, and a zero time
  // constant, give a weight of exactly one.
  function automatic logic [WF:0] decay_weight(input logic [TW-1:0] e,
                                               input logic [TW-1:0] t);
    longint unsigned e64, t64, y, term, p, r;
    longint          series;
    e64 = e;
    t64 = t;
    if (e64 >= (t64 << 4)) begin
      return WEIGHT_ONE[WF:0];
    end
    y      = (e64 << 27) / t64;
    term   = longint'(1) << 31;
    series = longint'(term);
    for (int n = 1; n <= 12; n++) begin
      term = ((term * y) >> 31) / longint'(n);
      if (n % 2 == 1) begin
        series = series - longint'(term);
      end else begin
        series = series + longint'(term);
      end
    end
    if (series < 0) begin
      series = 0;
    end
    if (series > (longint'(1) << 31)) begin
      series = longint'(1) << 31;
    end
    p = series;
    repeat (4) begin
      p = (p * p + (longint'(1) << 30)) >> 31;
    end
    r = (p + (longint'(1) << (30 - WF))) >> (31 - WF);
    if (r > WEIGHT_ONE) begin
      r = WEIGHT_ONE;
    end
    return WEIGHT_ONE[WF:0] - r[WF:0];
  endfunction

  // Folds one accepted sample beat into the predicted average and queues the
  // result beat that it must produce. The first sample simply loads the
  // average; the rest are rounded to nearest with halves going upwards, which
  // an arithmetic shift of the biased sum gives directly.
  task automatic blend_sample(input logic signed [SAMPLE_W-1:0] s,
                              input logic [TW-1:0] e);
    longint       alpha, mix;
    ewma_result_t due;
    if (!model_primed) begin
      model_average = s;
      model_primed  = 1'b1;
    end else begin
      alpha = longint'(decay_weight(e, model_tau));
      mix   = alpha * longint'(s) + (WEIGHT_ONE - alpha) * longint'(model_average);
      mix   = (mix + WEIGHT_HALF) >>> WF;
      model_average = mix[SAMPLE_W-1:0];
    end
    due.average = model_average;
    due.primed  = model_primed;
    pending_averages.push_back(due);
  endtask

  // --------------------------------------------------------------------------
  // Result side: random stalls and the check of every accepted beat
  // --------------------------------------------------------------------------

  task automatic check_average();
    ewma_result_t due;
    if (pending_averages.size() == 0) begin
      $display("%0t: result beat with nothing outstanding: average %0d primed %0b",
               $time, average_o, primed_o);
      fault_count++;
    end else begin
      due = pending_averages.pop_front();
      if (average_o !== due.average) begin
        $display("%0t: average mismatch: expected %0d, actual %0d",
                 $time, $signed(due.average), average_o);
        fault_count++;
      end
      if (primed_o !== due.primed) begin
        $display("%0t: primed mismatch: expected %0b, actual %0b",
                 $time, due.primed, primed_o);
        fault_count++;
      end
    end
  endtask

  // Outputs are sampled at the edge itself, so the values seen are the ones
  // that the handshake used; the stall for the next cycle is then redrawn.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      check_average();
    end
    out_stall_i <= ($urandom_range(0, 99) < out_stall_pct);
  end

  // --------------------------------------------------------------------------
  // Sample side
  // --------------------------------------------------------------------------

  // Presents one sample beat, after a random gap when the sender is set to
  // idle, and holds it until the block takes it. Valid is left high so that a
  // following beat can go out back to back; it is only lowered for a gap or
  // when the sender stops.
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] s,
                             input logic [TW-1:0] e);
    if ($urandom_range(0, 99) < in_gap_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < in_gap_pct);
    end
    in_valid_i      <= 1'b1;
    sample_i        <= s;
    elapsed_ticks_i <= e;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    blend_sample(s, e);
  endtask

  // Stops the sender and waits until every predicted result has been taken,
  // which leaves the block idle as there is only ever one item in work.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (pending_averages.size() != 0) @(posedge clk_i);
  endtask

  // Writes the time constant; only called while the block is idle.
  task automatic write_time_constant(input logic [TW-1:0] t);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= t;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    model_tau    = t;
    cfg_valid_i <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Random content
  // --------------------------------------------------------------------------

  function automatic logic signed [SAMPLE_W-1:0] random_sample();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(0, 7))
      0:       return MOST_NEGATIVE;
      1:       return MOST_POSITIVE;
      2:       return {{14{r[17]}}, r[17:0]};  // small values near zero
      default: return r;
    endcase
  endfunction

  // Intervals are mostly spread over the sixteen time constants in which the
  // series is used, with a share right at the large-interval boundary, some
  // zero intervals and some drawn over the whole field.
  function automatic logic [TW-1:0] random_elapsed(input logic [TW-1:0] t);
    longint span;
    case ($urandom_range(0, 9))
      0:       span = 0;
      1:       span = longint'($urandom);
      2:       span = (longint'(t) << 4) - 1 + longint'($urandom_range(0, 2));
      default: span = (longint'(t) * longint'($urandom_range(0, 4095))) >> 8;
    endcase
    if (span < 0) begin
      span = 0;
    end
    if (span > longint'(MAX_TICKS)) begin
      span = longint'(MAX_TICKS);
    end
    return span[TW-1:0];
  endfunction

  function automatic logic [TW-1:0] random_time_constant();
    case ($urandom_range(0, 4))
      0:       return 32'd1;
      1:       return MAX_TICKS;
      2:       return $urandom_range(2, 100);
      3:       return $urandom_range(1000, 2000000);
      default: return $urandom;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // The first sample after reset loads the average whatever its interval.
  task automatic test_first_sample();
    send_sample(MOST_NEGATIVE, MAX_TICKS);
  endtask

  // Runs on the time constant left by reset: a zero interval keeps the
  // average, short and long intervals blend, and from sixteen time constants
  // upwards the sample replaces the average outright.
  task automatic test_reset_time_constant();
    send_sample(MOST_POSITIVE, 32'd0);
    send_sample(MOST_POSITIVE, 32'd1);
    send_sample(32'sd0, RESET_TAU);
    send_sample(MOST_POSITIVE, 32'd15999999);
    send_sample(-32'sd1, 32'd16000000);
    send_sample(MOST_NEGATIVE, MAX_TICKS);
    send_sample(MOST_POSITIVE, 32'd8000000);
    drain_results();
  endtask

  // A zero time constant always takes the large-interval path, even when the
  // interval is zero as well.
  task automatic test_zero_time_constant();
    write_time_constant(32'd0);
    send_sample(32'sh0001_8000, 32'd0);
    send_sample(MOST_NEGATIVE, 32'd5);
    send_sample(MOST_POSITIVE, MAX_TICKS);
    drain_results();
  endtask

  // The smallest legal time constant puts the boundary at sixteen ticks.
  task automatic test_unit_time_constant();
    write_time_constant(32'd1);
    send_sample(MOST_NEGATIVE, 32'd0);
    send_sample(MOST_NEGATIVE, 32'd1);
    send_sample(32'sh0000_0001, 32'd15);
    send_sample(MOST_POSITIVE, 32'd16);
    send_sample(32'sh0000_0000, 32'd2);
    drain_results();
  endtask

  // The largest time constant never reaches the boundary, even for the longest
  // interval the field can carry; the shorter intervals give small weights.
  task automatic test_max_time_constant();
    write_time_constant(MAX_TICKS);
    send_sample(MOST_NEGATIVE, MAX_TICKS);
    send_sample(MOST_POSITIVE, 32'd1);
    send_sample(-32'sh0001_0000, 32'h0800_0000);
    drain_results();
  endtask

  // The sender goes quiet after every few beats until all results are back,
  // so the block repeatedly starts from idle while the receiver stalls.
  task automatic test_sender_waits();
    in_gap_pct    = 0;
    out_stall_pct = 56;
    write_time_constant(random_time_constant());
    repeat (6) begin
      repeat ($urandom_range(1, 5)) send_sample(random_sample(), random_elapsed(model_tau));
      drain_results();
    end
  endtask

  // Bulk traffic in four idling patterns. Each pattern runs once with one of
  // the corner time constants and once with a random one.
  task automatic test_random_traffic();
    logic [TW-1:0] corner_tau [4];
    corner_tau = '{32'd1, MAX_TICKS, RESET_TAU, 32'd37};
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          in_gap_pct    = 0;
          out_stall_pct = 0;
        end
        1: begin
          in_gap_pct    = 56;
          out_stall_pct = 0;
        end
        2: begin
          in_gap_pct    = 0;
          out_stall_pct = 56;
        end
        default: begin
          in_gap_pct    = 23;
          out_stall_pct = 23;
        end
      endcase
      for (int half = 0; half < 2; half++) begin
        drain_results();
        write_time_constant(half == 0 ? corner_tau[ph] : random_time_constant());
        repeat (150) send_sample(random_sample(), random_elapsed(model_tau));
      end
    end
    drain_results();
  endtask

  // --------------------------------------------------------------------------
  // Sequence and end of run
  // --------------------------------------------------------------------------

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_first_sample();
    test_reset_time_constant();
    test_zero_time_constant();
    test_unit_time_constant();
    test_max_time_constant();
    test_sender_waits();
    test_random_traffic();

    // Everything predicted has arrived; give the block time to show any
    // stray beat before the verdict.
    drain_results();
    repeat (150) @(posedge clk_i);
    if (fault_count == 0 && pending_averages.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Guard against a hung handshake: far beyond the slowest correct run.
  initial begin
    #20_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
